// ----- rtl/kpd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants of the keypad scanner and carrier transmitter.
// ----------------------------------------------------------------------------
package kpd_pkg;

  localparam int ROWS = 4;
  localparam int KEY_CODE_W = 8;
  localparam int DRIVE_W = 4;

  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_BAUD = 1'b1;

  // Column c, row r sits at index 4*c + r and holds the hex digit 15 - c - 4*r.
  localparam logic [KEY_CODE_W-1:0] KEY_CHAR [16] = '{
    8'h46, 8'h42, 8'h37, 8'h33,
    8'h45, 8'h41, 8'h36, 8'h32,
    8'h44, 8'h39, 8'h35, 8'h31,
    8'h43, 8'h38, 8'h34, 8'h30
  };

  typedef struct packed {
    logic                  pressed;
    logic [KEY_CODE_W-1:0] code;
  } key_t;

  typedef struct packed {
    logic carrier_on;
    logic tx_busy;
  } tx_status_t;

  typedef struct packed {
    logic [DRIVE_W-1:0]    column_drive;
    logic                  key_event;
    logic [KEY_CODE_W-1:0] key_code;
    logic                  carrier_on;
    logic                  tx_busy;
  } result_t;

endpackage

// ----- rtl/kpd_if.sv -----
// ----------------------------------------------------------------------------
// kpd_tick_if / kpd_result_if
// Valid/ready channels for scan and baud ticks and for the per-tick report.
// ----------------------------------------------------------------------------
interface kpd_tick_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] row_levels;

  modport source (output valid, kind, row_levels, input ready);
  modport sink (input valid, kind, row_levels, output ready);
endinterface

interface kpd_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] column_drive;
  logic       key_event;
  logic [7:0] key_code;
  logic       carrier_on;
  logic       tx_busy;

  modport source (output valid, column_drive, key_event, key_code, carrier_on, tx_busy,
                  input ready);
  modport sink (input valid, column_drive, key_event, key_code, carrier_on, tx_busy,
                output ready);
endinterface

// ----- rtl/kpd_scan.sv -----
// ----------------------------------------------------------------------------
// kpd_scan
// Column sequencer, two-sample key history and press detection per column.
// ----------------------------------------------------------------------------
module kpd_scan
  import kpd_pkg::*;
#(
  parameter int NUM_COLUMNS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [ROWS-1:0]    row_levels,
  output key_t               hit,
  output logic [DRIVE_W-1:0] column_drive
);

  localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

  logic [COL_W-1:0] active_column;
  logic [COL_W-1:0] active_column_next;
  logic [COL_W-1:0] column_after;
  logic [ROWS-1:0]  recent_sample [NUM_COLUMNS];
  logic [ROWS-1:0]  older_sample [NUM_COLUMNS];
  logic [ROWS-1:0]  recent_row;
  logic [ROWS-1:0]  older_row;
  logic [1:0]       table_column;

  assign recent_row   = recent_sample[active_column];
  assign older_row    = older_sample[active_column];
  assign table_column = 2'(active_column);

  assign active_column_next = (active_column == COL_W'(NUM_COLUMNS - 1)) ?
                              '0 : active_column + 1'b1;
  assign column_after = step ? active_column_next : active_column;

  always_comb begin
    hit = '0;
    for (int i = 0; i < ROWS; i++) begin
      if (step && !row_levels[i] && !recent_row[i] && older_row[i]) begin
        hit.pressed = 1'b1;
        hit.code    = KEY_CHAR[{table_column, 2'(i)}];
      end
    end
  end

  always_comb begin
    column_drive = '0;
    for (int j = 0; j < DRIVE_W; j++) begin
      if (j < NUM_COLUMNS) begin
        column_drive[j] = (column_after == COL_W'(j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_column <= '0;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        recent_sample[c] <= '1;
        older_sample[c]  <= '1;
      end
    end else if (step) begin
      older_sample[active_column]  <= recent_row;
      recent_sample[active_column] <= row_levels;
      active_column                <= active_column_next;
    end
  end

`ifndef SYNTHESIS
  a_column_in_range: assert property (@(posedge clk) disable iff (rst)
    active_column <= COL_W'(NUM_COLUMNS - 1))
    else $error("active column beyond the last column");

  a_drive_one_hot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(column_drive))
    else $error("more than one column driven");

  a_press_only_on_scan: assert property (@(posedge clk) disable iff (rst)
    hit.pressed |-> step)
    else $error("press reported without a scan tick");
`endif

endmodule

// ----- rtl/kpd_uart_tx.sv -----
// ----------------------------------------------------------------------------
// kpd_uart_tx
// Frame sender on the carrier line: start bit, data bits LSB first, stop bit.
// ----------------------------------------------------------------------------
module kpd_uart_tx
  import kpd_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  baud,
  input  key_t                  hit,
  output tx_status_t            status_next
);

  localparam int CNT_W = $clog2(DATA_BITS + 2);

  logic [DATA_BITS-1:0] frame_byte;
  logic [DATA_BITS-1:0] frame_shifted;
  logic [CNT_W-1:0]     bit_count;
  logic [CNT_W-1:0]     bit_count_next;
  logic                 busy_flag;
  logic                 busy_flag_next;
  logic                 carrier_level;
  logic                 carrier_level_next;
  logic                 start;

  assign start         = hit.pressed && !busy_flag;
  assign frame_shifted = frame_byte >> bit_count;

  always_comb begin
    bit_count_next     = bit_count;
    busy_flag_next     = busy_flag;
    carrier_level_next = carrier_level;
    if (start) begin
      bit_count_next     = '0;
      busy_flag_next     = 1'b1;
      carrier_level_next = 1'b1;
    end else if (baud && busy_flag) begin
      if (bit_count < CNT_W'(DATA_BITS)) begin
        carrier_level_next = !frame_shifted[0];
        bit_count_next     = bit_count + 1'b1;
      end else if (bit_count == CNT_W'(DATA_BITS)) begin
        carrier_level_next = 1'b0;
        bit_count_next     = bit_count + 1'b1;
      end else begin
        busy_flag_next = 1'b0;
        bit_count_next = '0;
      end
    end
  end

  assign status_next.carrier_on = carrier_level_next;
  assign status_next.tx_busy    = busy_flag_next;

  always_ff @(posedge clk) begin
    if (start) begin
      frame_byte <= hit.code[DATA_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_count     <= '0;
      busy_flag     <= 1'b0;
      carrier_level <= 1'b0;
    end else begin
      bit_count     <= bit_count_next;
      busy_flag     <= busy_flag_next;
      carrier_level <= carrier_level_next;
    end
  end

`ifndef SYNTHESIS
  a_idle_line_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy_flag |-> (!carrier_level && bit_count == '0))
    else $error("carrier or bit count active while idle");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    bit_count <= CNT_W'(DATA_BITS + 1))
    else $error("bit count ran past the stop bit");

  a_busy_ignores_press: assert property (@(posedge clk) disable iff (rst)
    (busy_flag && hit.pressed && !baud) |=> $stable(frame_byte))
    else $error("press during a frame changed the frame");
`endif

endmodule

// ----- rtl/keypad_scan_debounce_uart_tx_unit.sv -----
// ----------------------------------------------------------------------------
// keypad_scan_debounce_uart_tx_unit
// 4x4 keypad scanner with debounce, hex key mapping and a carrier-line UART.
// ----------------------------------------------------------------------------
// Usage: each beat on the tick channel is either a scan tick (kind 0, with the
// row levels seen on the column driven now) or a baud tick (kind 1). Every
// accepted tick gives exactly one beat on the report channel: the column to
// drive next, a debounced press with its ASCII hex digit, and the state of
// the carrier line and the transmitter after that tick.
// All work for a tick is done in the cycle it is accepted, and its report is
// registered: one tick per cycle is sustained while the report side is ready.
// The report register is backed by a one-beat skid register, so one more
// tick is taken while a report waits; tick ready drops only when both hold
// a beat. Reset drives column 0 next, marks every key released and leaves the
// transmitter idle with the carrier off; no report is pending after reset.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_uart_tx_unit
  import kpd_pkg::*;
#(
  parameter int NUM_COLUMNS = 4,
  parameter int DATA_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  kpd_tick_if.sink       tick,
  kpd_result_if.source   report
);

  logic       accept;
  logic       scan_step;
  logic       baud_step;
  key_t       hit;
  tx_status_t status_next;
  logic [DRIVE_W-1:0] column_drive;
  result_t    result_next;
  result_t    out_q;
  result_t    skid_q;
  logic       out_valid;
  logic       skid_valid;

  assign tick.ready = !skid_valid;
  assign accept     = tick.valid && !skid_valid;
  assign scan_step  = accept && (tick.kind == KIND_SCAN);
  assign baud_step  = accept && (tick.kind == KIND_BAUD);

  kpd_scan #(
    .NUM_COLUMNS(NUM_COLUMNS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .step        (scan_step),
    .row_levels  (tick.row_levels),
    .hit         (hit),
    .column_drive(column_drive)
  );

  kpd_uart_tx #(
    .DATA_BITS(DATA_BITS)
  ) u_tx (
    .clk        (clk),
    .rst        (rst),
    .baud       (baud_step),
    .hit        (hit),
    .status_next(status_next)
  );

  assign result_next.column_drive = column_drive;
  assign result_next.key_event    = hit.pressed;
  assign result_next.key_code     = hit.code;
  assign result_next.carrier_on   = status_next.carrier_on;
  assign result_next.tx_busy      = status_next.tx_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_valid || report.ready) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_valid && report.ready) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid || report.ready) begin
        out_q <= result_next;
      end else begin
        skid_q <= result_next;
      end
    end else if (out_valid && report.ready && skid_valid) begin
      out_q <= skid_q;
    end
  end

  assign report.valid        = out_valid;
  assign report.column_drive = out_q.column_drive;
  assign report.key_event    = out_q.key_event;
  assign report.key_code     = out_q.key_code;
  assign report.carrier_on   = out_q.carrier_on;
  assign report.tx_busy      = out_q.tx_busy;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a beat while the report register is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !report.ready) |=> skid_valid)
    else $error("tick accepted during a stall was not kept in the skid register");

  a_report_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !report.ready) |=> (out_valid && $stable(out_q)))
    else $error("report beat changed while the receiver stalled");
`endif

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the keypad scanner with debounce and carrier-line transmitter.
// A queue of scan and baud ticks feeds a driver that idles at random. A
// monitor keeps a model of the key history, the column counter and the
// transmitter, and checks every report beat against the oldest prediction
// while the report side stalls at random. The stimulus is mostly keypresses
// that pass the debounce, mixed with frame-draining baud bursts and noise.
// ----------------------------------------------------------------------------
module tb_top
  import kpd_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS = 4;
  localparam int NBITS = 8;
  localparam int RANDOM_TICKS = 2000;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic       kind;
    logic [3:0] rows;
  } tick_beat_t;

  logic clk;
  logic rst;

  kpd_tick_if tick_ch ();
  kpd_result_if rep_ch ();

  keypad_scan_debounce_uart_tx_unit #(
    .NUM_COLUMNS(NCOLS),
    .DATA_BITS(NBITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .tick(tick_ch),
    .report(rep_ch)
  );

  tick_beat_t pending_ticks[$];
  result_t    expected_reports[$];
  int         gen_col;
  int         error_count;
  int         quiet_cycles;
  int         gap_left;
  int         stall_left;
  logic       tick_took;

  // Model state of the scanner and the transmitter.
  logic [1:0] col_now;
  logic       recent_level [16];
  logic       older_level [16];
  logic [7:0] frame_code;
  int         frame_pos;
  logic       tx_active;
  logic       carrier;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_scan(input logic [3:0] rows);
    tick_beat_t b;
    b.kind = KIND_SCAN;
    b.rows = rows;
    pending_ticks.push_back(b);
    gen_col = (gen_col + 1) % NCOLS;
  endtask

  task automatic push_baud();
    tick_beat_t b;
    b.kind = KIND_BAUD;
    b.rows = 4'($urandom);
    pending_ticks.push_back(b);
  endtask

  // Three scan rounds: the chosen rows of the target column read released,
  // then pressed twice, which completes the debounce on the last round.
  task automatic press_keys(input int target, input logic [3:0] low_rows);
    int seen;
    logic [3:0] r;
    seen = 0;
    repeat (3 * NCOLS) begin
      if ($urandom_range(0, 3) == 0) push_baud();
      if (gen_col == target) begin
        r = (seen == 0) ? 4'hF : ~low_rows;
        seen++;
      end else begin
        r = $urandom_range(0, 1) ? 4'hF : 4'($urandom);
      end
      push_scan(r);
    end
  endtask

  task automatic model_reset();
    col_now = '0;
    for (int k = 0; k < 16; k++) begin
      recent_level[k] = 1'b1;
      older_level[k] = 1'b1;
    end
    frame_code = '0;
    frame_pos = 0;
    tx_active = 1'b0;
    carrier = 1'b0;
  endtask

  task automatic predict_report(input tick_beat_t b, output result_t r);
    int k;
    logic hit;
    logic [7:0] code;
    hit = 1'b0;
    code = '0;
    if (b.kind == KIND_BAUD) begin
      if (tx_active) begin
        if (frame_pos < NBITS) begin
          carrier = ~frame_code[frame_pos];
          frame_pos++;
        end else if (frame_pos == NBITS) begin
          carrier = 1'b0;
          frame_pos++;
        end else begin
          tx_active = 1'b0;
          frame_pos = 0;
        end
      end
    end else begin
      for (int i = 0; i < ROWS; i++) begin
        k = int'(col_now) * ROWS + i;
        if (!b.rows[i] && !recent_level[k] && older_level[k]) begin
          hit = 1'b1;
          code = KEY_CHAR[k];
        end
        older_level[k] = recent_level[k];
        recent_level[k] = b.rows[i];
      end
      if (hit && !tx_active) begin
        frame_code = code;
        frame_pos = 0;
        tx_active = 1'b1;
        carrier = 1'b1;
      end
      col_now = 2'((int'(col_now) + 1) % NCOLS);
    end
    r.column_drive = 4'b0001 << col_now;
    r.key_event = hit;
    r.key_code = code;
    r.carrier_on = carrier;
    r.tx_busy = tx_active;
  endtask

  task automatic report_mismatch(input string field, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: %s expected %0h got %0h", $realtime, field, want, got);
    error_count++;
  endtask

  // Monitor: the tick side feeds the model, the report side is checked.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    tick_beat_t b;
    if (rst) begin
      tick_took <= 1'b0;
      quiet_cycles = 0;
    end else begin
      tick_took <= tick_ch.valid && tick_ch.ready;
      if (rep_ch.valid && rep_ch.ready) begin
        got.column_drive = rep_ch.column_drive;
        got.key_event = rep_ch.key_event;
        got.key_code = rep_ch.key_code;
        got.carrier_on = rep_ch.carrier_on;
        got.tx_busy = rep_ch.tx_busy;
        if (expected_reports.size() == 0) begin
          $display("%0t: report beat with nothing expected", $realtime);
          error_count++;
        end else begin
          want = expected_reports.pop_front();
          if (got.column_drive !== want.column_drive)
            report_mismatch("column_drive", 8'(want.column_drive), 8'(got.column_drive));
          if (got.key_event !== want.key_event)
            report_mismatch("key_event", 8'(want.key_event), 8'(got.key_event));
          if (got.key_code !== want.key_code)
            report_mismatch("key_code", want.key_code, got.key_code);
          if (got.carrier_on !== want.carrier_on)
            report_mismatch("carrier_on", 8'(want.carrier_on), 8'(got.carrier_on));
          if (got.tx_busy !== want.tx_busy)
            report_mismatch("tx_busy", 8'(want.tx_busy), 8'(got.tx_busy));
        end
      end
      if (tick_ch.valid && tick_ch.ready) begin
        b.kind = tick_ch.kind;
        b.rows = tick_ch.row_levels;
        predict_report(b, want);
        expected_reports.push_back(want);
      end
      if ((tick_ch.valid && tick_ch.ready) || (rep_ch.valid && rep_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // Tick driver.
  always @(negedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
      gap_left = 0;
    end else if (tick_ch.valid && !tick_took) begin
      tick_ch.valid <= 1'b1;
    end else if (gap_left > 0) begin
      tick_ch.valid <= 1'b0;
      gap_left--;
    end else if (pending_ticks.size() > 0) begin
      tick_ch.kind <= pending_ticks[0].kind;
      tick_ch.row_levels <= pending_ticks[0].rows;
      void'(pending_ticks.pop_front());
      tick_ch.valid <= 1'b1;
      gap_left = pick_gap();
    end else begin
      tick_ch.valid <= 1'b0;
    end
  end

  // Report-side stalls.
  always @(negedge clk) begin
    if (rst) begin
      rep_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      rep_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rep_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    int r;
    tick_ch.valid = 1'b0;
    tick_ch.kind = KIND_SCAN;
    tick_ch.row_levels = 4'hF;
    rep_ch.ready = 1'b0;
    error_count = 0;
    gen_col = 0;
    rst = 1'b1;
    model_reset();

    // Directed: an idle baud tick, then rows 0 and 3 of column 0 pressed
    // together while column 1 has every row pressed, so the second press
    // lands while the first frame is on the line; the frame then drains.
    push_baud();
    repeat (NCOLS) push_scan(4'hF);
    repeat (2) begin
      push_scan(4'b0110);
      push_scan(4'b0000);
      push_scan(4'hF);
      push_scan(4'hF);
    end
    repeat (NBITS + 3) push_baud();

    while (pending_ticks.size() < RANDOM_TICKS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        press_keys($urandom_range(0, NCOLS - 1), 4'($urandom_range(1, 15)));
      end else if (r < 85) begin
        repeat ($urandom_range(NBITS, NBITS + 4)) push_baud();
      end else begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 1)) push_baud();
          else push_scan(4'($urandom));
        end
      end
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    while (pending_ticks.size() > 0 || tick_ch.valid) @(posedge clk);
    while (expected_reports.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/kpd_pkg.sv
rtl/kpd_if.sv
rtl/kpd_scan.sv
rtl/kpd_uart_tx.sv
rtl/keypad_scan_debounce_uart_tx_unit.sv
tb/tb_top.sv
